>>> sv/lsc_pkg.sv
// ----------------------------------------------------------------------------
// lsc_pkg
// Shared types, register indexes and sine polynomial constants for the
// lidar spherical to Cartesian unit.
// ----------------------------------------------------------------------------
`default_nettype none
package lsc_pkg;

	localparam int MAX_COLUMNS = 2048;
	localparam int MAX_ROWS    = 64;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_RANGE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_RANGE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_YAW_START   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_YAW_STEP    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PITCH_START = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PITCH_STEP  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_BEAM_TIME   = 3'd6;

	// Q30 coefficients of the odd sine polynomial
	localparam logic [30:0] COEF1 = 31'd1686629713;
	localparam logic [30:0] COEF3 = 31'd693598669;
	localparam logic [30:0] COEF5 = 31'd85569306;
	localparam logic [30:0] COEF7 = 31'd5026995;
	localparam logic [30:0] COEF9 = 31'd172272;

	typedef struct packed {
		logic [19:0] range_lo;
		logic [19:0] range_hi;
		logic [15:0] yaw_start;
		logic [15:0] yaw_step;
		logic [15:0] pitch_start;
		logic [15:0] pitch_step;
		logic [15:0] beam_time;
	} cfg_t;

	typedef struct packed {
		logic [19:0] range;
		logic [26:0] time_off;
		logic [15:0] inten;
		logic [5:0]  row;
		logic        pv;
		logic        last;
	} side_t;

	// One Horner step: c - (t2 * p) >> 30
	function automatic logic [30:0] horner(input logic [30:0] c, input logic [30:0] t2,
			input logic [30:0] p);
		logic [61:0] prod;
		prod = t2 * p;
		return c - prod[60:30];
	endfunction

endpackage
`default_nettype wire

>>> sv/lidar_spherical_to_cartesian_unit.sv
// ----------------------------------------------------------------------------
// lidar_spherical_to_cartesian_unit
// Converts lidar returns to Cartesian points through an eleven-stage pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   Returns enter on the s_* stream (one per cycle at most); points leave on
//   the m_* stream, with point_valid in m_tuser and scan_end in m_tlast.
//   Registers are written on the cfg_* channel, which is always ready; write
//   them only while no transaction is in flight.
// Throughput: one return per cycle unless the output stalls; the four sine units and
//   the three range multipliers are each fully pipelined, at most one multiply per stage.
// Returns outside the range window make no point; a dropped return that
//   ends the scan leaves as a zeroed marker with point_valid low.
// Reset clears all valid bits and loads the register defaults.
// When the receiver stalls a valid output, the whole pipeline holds and
//   s_tready falls; s_tready stays high while the output is empty or taken.
// ----------------------------------------------------------------------------
`default_nettype none
module lidar_spherical_to_cartesian_unit (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [55:0]  s_tdata,  // range_mm, intensity, column, row, zero pad
	input  wire logic         s_tlast,  // last_of_scan
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [111:0]      m_tdata,  // x_mm, y_mm, z_mm, time_offset_us, point_intensity, ring
	output logic              m_tuser,  // point_valid
	output logic              m_tlast,  // scan_end
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [19:0]  cfg_data
);

	localparam int NSTG = 11;

	lsc_pkg::cfg_t cfg;
	lsc_pkg::side_t side_s [1:10];
	logic vld_s [1:NSTG];

	logic [19:0] in_range;
	logic [10:0] in_col;
	logic [5:0]  in_row;
	logic        keep, en;

	logic [15:0] yaw_s1, pitch_s1;
	logic signed [15:0] sy, cy, sp, cp;
	logic signed [31:0] cpcy_s9, cpsy_s9;
	logic signed [36:0] zv_s9;
	logic signed [52:0] xv_s10, yv_s10;
	logic signed [20:0] z_s10;
	logic signed [20:0] x_s11, y_s11, z_s11;
	logic [26:0] time_s11;
	logic [15:0] inten_s11;
	logic [5:0]  ring_s11;
	logic        pv_s11, last_s11;

	logic [37:0] zsum;
	logic [53:0] xsum, ysum;

	lsc_cfg_regs u_cfg (
		.clk(clk), .arst_n(arst_n), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data), .cfg(cfg)
	);

	assign in_range = s_tdata[19:0];
	assign in_col   = s_tdata[46:36];
	assign in_row   = s_tdata[52:47];
	assign en       = !vld_s[NSTG] || m_tready;
	assign s_tready = en;

	assign keep = (cfg.range_lo < in_range) && (in_range < cfg.range_hi) &&
		(32'(in_col) < lsc_pkg::MAX_COLUMNS) && (32'(in_row) < lsc_pkg::MAX_ROWS);

	// Advance valid bits; drop returns that make no result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= NSTG; k++) vld_s[k] <= 1'b0;
		end else if (en) begin
			vld_s[1] <= s_tvalid && (keep || s_tlast);
			for (int k = 2; k <= NSTG; k++) vld_s[k] <= vld_s[k-1];
		end
	end

	// Form angles, time offset and side data
	always_ff @(posedge clk) begin
		if (en) begin
			yaw_s1   <= 16'(cfg.yaw_start + 16'(in_col * cfg.yaw_step));
			pitch_s1 <= 16'(cfg.pitch_start + 16'(in_row * cfg.pitch_step));
			side_s[1].range    <= in_range;
			side_s[1].time_off <= 27'(in_col) * 27'(cfg.beam_time);
			side_s[1].inten    <= s_tdata[35:20];
			side_s[1].row      <= in_row;
			side_s[1].pv       <= keep;
			side_s[1].last     <= s_tlast;
			for (int k = 2; k <= 10; k++) side_s[k] <= side_s[k-1];
		end
	end

	lsc_sin_pipe u_sin_yaw (.clk(clk), .en(en), .angle(yaw_s1), .sin_out(sy));
	lsc_sin_pipe u_cos_yaw (.clk(clk), .en(en), .angle(16'(yaw_s1 + 16'd16384)), .sin_out(cy));
	lsc_sin_pipe u_sin_pitch (.clk(clk), .en(en), .angle(pitch_s1), .sin_out(sp));
	lsc_sin_pipe u_cos_pitch (.clk(clk), .en(en), .angle(16'(pitch_s1 + 16'd16384)),
		.sin_out(cp));

	// Round half away from zero: (v + half - sign) >>> shift
	assign zsum = {zv_s9[36], zv_s9} + 38'd16384 - 38'(zv_s9[36]);
	assign xsum = {xv_s10[52], xv_s10} + 54'd536870912 - 54'(xv_s10[52]);
	assign ysum = {yv_s10[52], yv_s10} + 54'd536870912 - 54'(yv_s10[52]);

	// Multiply out the trigonometric products and round
	always_ff @(posedge clk) begin
		if (en) begin
			cpcy_s9 <= cp * cy;
			cpsy_s9 <= cp * sy;
			zv_s9   <= $signed({1'b0, side_s[8].range}) * sp;
			xv_s10  <= $signed({1'b0, side_s[9].range}) * cpcy_s9;
			yv_s10  <= $signed({1'b0, side_s[9].range}) * cpsy_s9;
			z_s10   <= $signed(zsum[35:15]);
			x_s11   <= side_s[10].pv ? $signed(xsum[50:30]) : 21'sd0;
			y_s11   <= side_s[10].pv ? $signed(ysum[50:30]) : 21'sd0;
			z_s11   <= side_s[10].pv ? z_s10 : 21'sd0;
			time_s11  <= side_s[10].pv ? side_s[10].time_off : '0;
			inten_s11 <= side_s[10].pv ? side_s[10].inten : '0;
			ring_s11  <= side_s[10].pv ? side_s[10].row : '0;
			pv_s11    <= side_s[10].pv;
			last_s11  <= side_s[10].last;
		end
	end

	assign m_tvalid = vld_s[NSTG];
	assign m_tdata  = {ring_s11, inten_s11, time_s11, z_s11, y_s11, x_s11};
	assign m_tuser  = pv_s11;
	assign m_tlast  = last_s11;

	a_marker_ends_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> m_tlast)
		else $error("marker result without scan end");
	a_marker_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata == '0))
		else $error("marker result carries data");
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && !$past(s_tready)))
		else $error("pipeline moved under stall");

endmodule
`default_nettype wire

>>> sv/lsc_cfg_regs.sv
// ----------------------------------------------------------------------------
// lsc_cfg_regs
// Configuration register file, written through a valid/ready channel.
// ----------------------------------------------------------------------------
`default_nettype none
module lsc_cfg_regs (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [lsc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [lsc_pkg::CFG_DATA_W-1:0]    cfg_data,
	output lsc_pkg::cfg_t                          cfg
);

	lsc_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// Write the addressed register; drop unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.range_lo    <= '0;
			cfg_q.range_hi    <= 20'hFFFFF;
			cfg_q.yaw_start   <= '0;
			cfg_q.yaw_step    <= '0;
			cfg_q.pitch_start <= '0;
			cfg_q.pitch_step  <= '0;
			cfg_q.beam_time   <= 16'd100;
		end else if (cfg_valid) begin
			case (cfg_index)
				lsc_pkg::REG_MIN_RANGE:   cfg_q.range_lo    <= cfg_data;
				lsc_pkg::REG_MAX_RANGE:   cfg_q.range_hi    <= cfg_data;
				lsc_pkg::REG_YAW_START:   cfg_q.yaw_start   <= cfg_data[15:0];
				lsc_pkg::REG_YAW_STEP:    cfg_q.yaw_step    <= cfg_data[15:0];
				lsc_pkg::REG_PITCH_START: cfg_q.pitch_start <= cfg_data[15:0];
				lsc_pkg::REG_PITCH_STEP:  cfg_q.pitch_step  <= cfg_data[15:0];
				lsc_pkg::REG_BEAM_TIME:   cfg_q.beam_time   <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

>>> sv/lsc_sin_pipe.sv
// ----------------------------------------------------------------------------
// lsc_sin_pipe
// Seven-stage Q1.15 sine of a 16-bit turn angle, at most one multiply a stage.
// ----------------------------------------------------------------------------
`default_nettype none
module lsc_sin_pipe (
	input  wire logic               clk,
	input  wire logic               en,
	input  wire logic [15:0]        angle,
	output logic signed [15:0]      sin_out
);

	logic [14:0] f_s    [1:5];
	logic [1:0]  quad_s [1:6];
	logic [30:0] t2_s   [1:4];
	logic [30:0] p_s    [2:5];
	logic [31:0] s_s6;
	logic signed [15:0] sin_s7;

	logic [14:0] f_in;
	logic [29:0] ff;
	logic [45:0] fp;
	logic [32:0] rnd;
	logic [15:0] mag;

	// Mirror the fraction in odd quadrants
	assign f_in = angle[14] ? 15'(15'd16384 - {1'b0, angle[13:0]}) : {1'b0, angle[13:0]};
	assign ff   = f_in * f_in;
	assign fp   = f_s[5] * p_s[5];
	assign rnd  = {1'b0, s_s6} + 33'd16384;
	assign mag  = (rnd[32:15] > 18'd32767) ? 16'd32767 : rnd[30:15];

	// Advance the polynomial pipeline
	always_ff @(posedge clk) begin
		if (en) begin
			f_s[1]    <= f_in;
			quad_s[1] <= angle[15:14];
			t2_s[1]   <= {ff[28:0], 2'b00};
			for (int k = 2; k <= 6; k++) begin
				quad_s[k] <= quad_s[k-1];
			end
			for (int k = 2; k <= 5; k++) begin
				f_s[k] <= f_s[k-1];
			end
			for (int k = 2; k <= 4; k++) begin
				t2_s[k] <= t2_s[k-1];
			end
			p_s[2] <= lsc_pkg::horner(lsc_pkg::COEF7, t2_s[1], lsc_pkg::COEF9);
			p_s[3] <= lsc_pkg::horner(lsc_pkg::COEF5, t2_s[2], p_s[2]);
			p_s[4] <= lsc_pkg::horner(lsc_pkg::COEF3, t2_s[3], p_s[3]);
			p_s[5] <= lsc_pkg::horner(lsc_pkg::COEF1, t2_s[4], p_s[4]);
			s_s6   <= fp[45:14];
			sin_s7 <= quad_s[6][1] ? -$signed(mag) : $signed(mag);
		end
	end

	assign sin_out = sin_s7;

endmodule
`default_nettype wire
